// ===== hdl/qrba_pkg.sv =====
// Shared types and constants for the quadrotor body acceleration pipeline.
`timescale 1ns / 1ps

package qrba_pkg;

  localparam int CFG_INDEX_W = 4;

  localparam logic [CFG_INDEX_W-1:0] REG_THRUST_ACCEL_GAIN = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TILT_GAIN         = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_YAW_GAIN          = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_TILT_DAMPING      = 4'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_YAW_DAMPING       = 4'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_HORIZONTAL_DRAG   = 4'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_VERTICAL_DRAG     = 4'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_GRAVITY           = 4'd7;

  localparam logic [30:0] GRAVITY_RESET = 31'd642689;

  typedef struct packed {
    logic signed [31:0] speed_front;
    logic signed [31:0] speed_rear;
    logic signed [31:0] speed_left;
    logic signed [31:0] speed_right;
    logic signed [31:0] spin_x;
    logic signed [31:0] spin_y;
    logic signed [31:0] spin_z;
    logic signed [31:0] velocity_x;
    logic signed [31:0] velocity_y;
    logic signed [31:0] velocity_z;
    logic        [47:0] thrust_direction;
  } item_t;

  typedef struct packed {
    logic signed [31:0] accel_x;
    logic signed [31:0] accel_y;
    logic signed [31:0] accel_z;
    logic signed [31:0] yaw_accel;
    logic signed [31:0] pitch_accel;
    logic signed [31:0] roll_accel;
  } result_t;

  typedef struct packed {
    logic [30:0] thrust_accel_gain;
    logic [30:0] tilt_gain;
    logic [30:0] yaw_gain;
    logic [30:0] tilt_damping;
    logic [30:0] yaw_damping;
    logic [30:0] horizontal_drag;
    logic [30:0] vertical_drag;
    logic [30:0] gravity;
  } cfg_t;

  // Load enables of a two-stage multiplier: product stage, then sum stage.
  typedef struct packed {
    logic prod;
    logic sum;
  } mul_en_t;

endpackage

// ===== hdl/quad_rotor_body_acceleration.sv =====
// Top level of the quadrotor body acceleration pipeline.
`timescale 1ns / 1ps

// Eight-stage pipeline that turns one rotor/velocity snapshot into three linear and three
// angular accelerations, saturated Q16.16. One transaction is taken every cycle unless the
// pipeline is stalled; the stages are squaring, sums and magnitudes, the two halves of the
// gain multipliers, the two halves of the thrust direction multipliers, drag and gravity
// subtraction, and the saturating output register. Each stage holds only while the stage
// after it is full and stalled, so a stall on result_ready fills bubbles before it reaches
// item_ready. Configuration writes are taken every cycle (cfg_ready is always high) and
// should be made while no transaction is in flight.
module quad_rotor_body_acceleration (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_ready,
  input  qrba_pkg::item_t                   item,
  output logic                              result_valid,
  input  logic                              result_ready,
  output qrba_pkg::result_t                 result,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [qrba_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [31:0]                       cfg_value
);

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic [46:0] square_q(input logic signed [31:0] v);
    logic [31:0] m;
    logic [63:0] p;
    m = mag32(v);
    p = {32'd0, m} * {32'd0, m};
    return p[62:16];
  endfunction

  function automatic logic signed [33:0] sext34(input logic signed [31:0] v);
    return $signed({{2{v[31]}}, v});
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -66'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  qrba_pkg::cfg_t cfg;

  logic [8:1] valid;
  logic [8:1] en;

  // stage 1: squares and the yaw speed sum
  logic [46:0]        s1_sq_front, s1_sq_rear, s1_sq_left, s1_sq_right;
  logic [46:0]        s1_drag_sq_x, s1_drag_sq_y, s1_drag_sq_z;
  logic               s1_drag_neg_x, s1_drag_neg_y, s1_drag_neg_z;
  logic signed [33:0] s1_yaw_diff;
  logic signed [31:0] s1_spin_x, s1_spin_y, s1_spin_z;
  logic [47:0]        s1_dir;

  // stage 2: magnitudes and signs feeding the gain multipliers
  logic [48:0] s2_thrust_mag;
  logic [46:0] s2_pitch_mag, s2_roll_mag;
  logic        s2_pitch_neg, s2_roll_neg;
  logic [33:0] s2_yaw_mag;
  logic        s2_yaw_neg;
  logic [31:0] s2_spin_x_mag, s2_spin_y_mag, s2_spin_z_mag;
  logic        s2_spin_x_neg, s2_spin_y_neg, s2_spin_z_neg;
  logic [46:0] s2_drag_sq_x, s2_drag_sq_y, s2_drag_sq_z;
  logic        s2_drag_neg_x, s2_drag_neg_y, s2_drag_neg_z;
  logic [47:0] s2_dir;

  logic [47:0] s3_dir, s4_dir;

  logic [48:0] sum4;
  logic [47:0] pitch_d, roll_d, pitch_m, roll_m;
  logic [33:0] yaw_m;

  qrba_pkg::mul_en_t gain_en, dir_en;

  logic signed [63:0] g_pitch, g_roll, g_yaw, g_spin_x, g_spin_y, g_spin_z;
  logic signed [63:0] g_total, g_drag_x, g_drag_y, g_drag_z;
  logic [46:0]        thrust_sat;
  logic signed [49:0] d_x, d_y, d_z;

  logic signed [64:0] s5_pitch, s5_roll, s5_yaw;
  logic signed [63:0] s5_drag_x, s5_drag_y, s5_drag_z;
  logic signed [31:0] s6_pitch, s6_roll, s6_yaw;
  logic signed [63:0] s6_drag_x, s6_drag_y, s6_drag_z;
  logic signed [64:0] s7_ax, s7_ay;
  logic signed [65:0] s7_az;
  logic signed [31:0] s7_pitch, s7_roll, s7_yaw;

  assign cfg_ready = 1'b1;

  qrba_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_value (cfg_value),
    .cfg       (cfg)
  );

  // a stage loads when it is empty or its content moves on
  always_comb begin
    en[8] = !valid[8] || result_ready;
    for (int k = 7; k >= 1; k--) begin
      en[k] = !valid[k] || en[k+1];
    end
  end

  assign item_ready   = en[1];
  assign result_valid = valid[8];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en[1]) valid[1] <= item_valid;
      for (int k = 2; k <= 8; k++) begin
        if (en[k]) valid[k] <= valid[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_sq_front   <= square_q(item.speed_front);
      s1_sq_rear    <= square_q(item.speed_rear);
      s1_sq_left    <= square_q(item.speed_left);
      s1_sq_right   <= square_q(item.speed_right);
      s1_drag_sq_x  <= square_q(item.velocity_x);
      s1_drag_sq_y  <= square_q(item.velocity_y);
      s1_drag_sq_z  <= square_q(item.velocity_z);
      s1_drag_neg_x <= item.velocity_x[31];
      s1_drag_neg_y <= item.velocity_y[31];
      s1_drag_neg_z <= item.velocity_z[31];
      s1_yaw_diff   <= sext34(item.speed_left) + sext34(item.speed_right)
                     - sext34(item.speed_front) - sext34(item.speed_rear);
      s1_spin_x     <= item.spin_x;
      s1_spin_y     <= item.spin_y;
      s1_spin_z     <= item.spin_z;
      s1_dir        <= item.thrust_direction;
    end
  end

  always_comb begin
    sum4    = {2'd0, s1_sq_front} + {2'd0, s1_sq_rear}
            + {2'd0, s1_sq_left} + {2'd0, s1_sq_right};
    pitch_d = {1'b0, s1_sq_left} - {1'b0, s1_sq_right};
    roll_d  = {1'b0, s1_sq_front} - {1'b0, s1_sq_rear};
    pitch_m = pitch_d[47] ? (~pitch_d + 48'd1) : pitch_d;
    roll_m  = roll_d[47] ? (~roll_d + 48'd1) : roll_d;
    yaw_m   = s1_yaw_diff[33] ? (~s1_yaw_diff + 34'd1) : s1_yaw_diff;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_thrust_mag <= sum4;
      s2_pitch_mag  <= pitch_m[46:0];
      s2_pitch_neg  <= pitch_d[47];
      s2_roll_mag   <= roll_m[46:0];
      s2_roll_neg   <= roll_d[47];
      s2_yaw_mag    <= yaw_m;
      s2_yaw_neg    <= s1_yaw_diff[33];
      s2_spin_x_mag <= mag32(s1_spin_x);
      s2_spin_y_mag <= mag32(s1_spin_y);
      s2_spin_z_mag <= mag32(s1_spin_z);
      s2_spin_x_neg <= s1_spin_x[31];
      s2_spin_y_neg <= s1_spin_y[31];
      s2_spin_z_neg <= s1_spin_z[31];
      s2_drag_sq_x  <= s1_drag_sq_x;
      s2_drag_sq_y  <= s1_drag_sq_y;
      s2_drag_sq_z  <= s1_drag_sq_z;
      s2_drag_neg_x <= s1_drag_neg_x;
      s2_drag_neg_y <= s1_drag_neg_y;
      s2_drag_neg_z <= s1_drag_neg_z;
      s2_dir        <= s1_dir;
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) s3_dir <= s2_dir;
    if (en[4]) s4_dir <= s3_dir;
  end

  assign gain_en = '{prod: en[3], sum: en[4]};
  assign dir_en  = '{prod: en[5], sum: en[6]};

  qrba_gain_mul u_gain_total (
    .clk (clk), .en (gain_en), .mag (s2_thrust_mag), .neg (1'b0),
    .gain (cfg.thrust_accel_gain), .prod (g_total)
  );
  qrba_gain_mul u_gain_pitch (
    .clk (clk), .en (gain_en), .mag ({2'd0, s2_pitch_mag}), .neg (s2_pitch_neg),
    .gain (cfg.tilt_gain), .prod (g_pitch)
  );
  qrba_gain_mul u_gain_roll (
    .clk (clk), .en (gain_en), .mag ({2'd0, s2_roll_mag}), .neg (s2_roll_neg),
    .gain (cfg.tilt_gain), .prod (g_roll)
  );
  qrba_gain_mul u_gain_yaw (
    .clk (clk), .en (gain_en), .mag ({15'd0, s2_yaw_mag}), .neg (s2_yaw_neg),
    .gain (cfg.yaw_gain), .prod (g_yaw)
  );
  qrba_gain_mul u_gain_spin_x (
    .clk (clk), .en (gain_en), .mag ({17'd0, s2_spin_x_mag}), .neg (s2_spin_x_neg),
    .gain (cfg.tilt_damping), .prod (g_spin_x)
  );
  qrba_gain_mul u_gain_spin_y (
    .clk (clk), .en (gain_en), .mag ({17'd0, s2_spin_y_mag}), .neg (s2_spin_y_neg),
    .gain (cfg.tilt_damping), .prod (g_spin_y)
  );
  qrba_gain_mul u_gain_spin_z (
    .clk (clk), .en (gain_en), .mag ({17'd0, s2_spin_z_mag}), .neg (s2_spin_z_neg),
    .gain (cfg.yaw_damping), .prod (g_spin_z)
  );
  qrba_gain_mul u_gain_drag_x (
    .clk (clk), .en (gain_en), .mag ({2'd0, s2_drag_sq_x}), .neg (s2_drag_neg_x),
    .gain (cfg.horizontal_drag), .prod (g_drag_x)
  );
  qrba_gain_mul u_gain_drag_y (
    .clk (clk), .en (gain_en), .mag ({2'd0, s2_drag_sq_y}), .neg (s2_drag_neg_y),
    .gain (cfg.horizontal_drag), .prod (g_drag_y)
  );
  qrba_gain_mul u_gain_drag_z (
    .clk (clk), .en (gain_en), .mag ({2'd0, s2_drag_sq_z}), .neg (s2_drag_neg_z),
    .gain (cfg.vertical_drag), .prod (g_drag_z)
  );

  // total thrust is never negative; clamp it below 2^47
  assign thrust_sat = (|g_total[62:47]) ? {47{1'b1}} : g_total[46:0];

  qrba_dir_mul u_dir_x (
    .clk (clk), .en (dir_en), .thrust (thrust_sat), .comp ($signed(s4_dir[15:0])), .prod (d_x)
  );
  qrba_dir_mul u_dir_y (
    .clk (clk), .en (dir_en), .thrust (thrust_sat), .comp ($signed(s4_dir[31:16])), .prod (d_y)
  );
  qrba_dir_mul u_dir_z (
    .clk (clk), .en (dir_en), .thrust (thrust_sat), .comp ($signed(s4_dir[47:32])), .prod (d_z)
  );

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_pitch  <= $signed({g_pitch[63], g_pitch} - {g_spin_y[63], g_spin_y});
      s5_roll   <= $signed({g_roll[63], g_roll} - {g_spin_x[63], g_spin_x});
      s5_yaw    <= $signed({g_yaw[63], g_yaw} - {g_spin_z[63], g_spin_z});
      s5_drag_x <= g_drag_x;
      s5_drag_y <= g_drag_y;
      s5_drag_z <= g_drag_z;
    end
    if (en[6]) begin
      s6_pitch  <= sat32($signed({s5_pitch[64], s5_pitch}));
      s6_roll   <= sat32($signed({s5_roll[64], s5_roll}));
      s6_yaw    <= sat32($signed({s5_yaw[64], s5_yaw}));
      s6_drag_x <= s5_drag_x;
      s6_drag_y <= s5_drag_y;
      s6_drag_z <= s5_drag_z;
    end
    if (en[7]) begin
      s7_ax    <= $signed({{15{d_x[49]}}, d_x} - {s6_drag_x[63], s6_drag_x});
      s7_ay    <= $signed({{15{d_y[49]}}, d_y} - {s6_drag_y[63], s6_drag_y});
      s7_az    <= $signed({{16{d_z[49]}}, d_z} - {{2{s6_drag_z[63]}}, s6_drag_z}
                          - {35'd0, cfg.gravity});
      s7_pitch <= s6_pitch;
      s7_roll  <= s6_roll;
      s7_yaw   <= s6_yaw;
    end
    if (en[8]) begin
      result.accel_x     <= sat32($signed({s7_ax[64], s7_ax}));
      result.accel_y     <= sat32($signed({s7_ay[64], s7_ay}));
      result.accel_z     <= sat32(s7_az);
      result.yaw_accel   <= s7_yaw;
      result.pitch_accel <= s7_pitch;
      result.roll_accel  <= s7_roll;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> (result_valid && !result_ready))
    else $error("input stalled without back-pressure at the output");

  assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(valid[7]))
    else $error("result appeared without a transaction in the stage before it");

  assert property (@(posedge clk) disable iff (rst)
    (valid[7] && !valid[8]) |=> valid[8])
    else $error("transaction failed to advance into an empty output register");

endmodule

// ===== hdl/qrba_cfg_regs.sv =====
// Gain, damping, drag and gravity registers with their write decoder.
`timescale 1ns / 1ps

module qrba_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  input  logic [qrba_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [31:0]                       cfg_value,
  output qrba_pkg::cfg_t                    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      // gravity is the last field, so it sits in the low bits
      cfg <= {217'd0, qrba_pkg::GRAVITY_RESET};
    end else if (cfg_valid) begin
      // keep the low 31 bits; drop writes past the register list
      unique case (cfg_index)
        qrba_pkg::REG_THRUST_ACCEL_GAIN: cfg.thrust_accel_gain <= cfg_value[30:0];
        qrba_pkg::REG_TILT_GAIN:         cfg.tilt_gain         <= cfg_value[30:0];
        qrba_pkg::REG_YAW_GAIN:          cfg.yaw_gain          <= cfg_value[30:0];
        qrba_pkg::REG_TILT_DAMPING:      cfg.tilt_damping      <= cfg_value[30:0];
        qrba_pkg::REG_YAW_DAMPING:       cfg.yaw_damping       <= cfg_value[30:0];
        qrba_pkg::REG_HORIZONTAL_DRAG:   cfg.horizontal_drag   <= cfg_value[30:0];
        qrba_pkg::REG_VERTICAL_DRAG:     cfg.vertical_drag     <= cfg_value[30:0];
        qrba_pkg::REG_GRAVITY:           cfg.gravity           <= cfg_value[30:0];
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) rst |=> (cfg.gravity == qrba_pkg::GRAVITY_RESET))
    else $error("gravity register not at its reset value after reset");

endmodule

// ===== hdl/qrba_gain_mul.sv =====
// Two-stage sign-magnitude multiply of a Q33.16 magnitude by a Q15.16 gain.
`timescale 1ns / 1ps

module qrba_gain_mul (
  input  logic                clk,
  input  qrba_pkg::mul_en_t   en,
  input  logic [48:0]         mag,
  input  logic                neg,
  input  logic [30:0]         gain,
  output logic signed [63:0]  prod
);

  logic [62:0] hi_prod;
  logic [46:0] lo_prod;
  logic        neg_q;
  logic [62:0] sum;

  // split the magnitude at the binary point so each product stays narrow
  always_ff @(posedge clk) begin
    if (en.prod) begin
      hi_prod <= {30'd0, mag[48:16]} * {32'd0, gain};
      lo_prod <= {31'd0, mag[15:0]} * {16'd0, gain};
      neg_q   <= neg;
    end
  end

  assign sum = hi_prod + 63'(lo_prod[46:16]);

  always_ff @(posedge clk) begin
    if (en.sum) begin
      prod <= neg_q ? $signed(~{1'b0, sum} + 64'd1) : $signed({1'b0, sum});
    end
  end

endmodule

// ===== hdl/qrba_dir_mul.sv =====
// Two-stage product of total thrust with one signed Q2.14 direction component.
`timescale 1ns / 1ps

module qrba_dir_mul (
  input  logic                clk,
  input  qrba_pkg::mul_en_t   en,
  input  logic [46:0]         thrust,
  input  logic signed [15:0]  comp,
  output logic signed [49:0]  prod
);

  logic [15:0] comp_mag;
  logic [38:0] p_hi;
  logic [39:0] p_lo;
  logic        neg_q;
  logic [62:0] full;
  logic [48:0] mag;

  assign comp_mag = comp[15] ? (~comp + 16'd1) : comp;

  always_ff @(posedge clk) begin
    if (en.prod) begin
      p_hi  <= {16'd0, thrust[46:24]} * {23'd0, comp_mag};
      p_lo  <= {16'd0, thrust[23:0]} * {24'd0, comp_mag};
      neg_q <= comp[15];
    end
  end

  assign full = {p_hi, 24'd0} + 63'(p_lo);
  assign mag  = full[62:14];

  always_ff @(posedge clk) begin
    if (en.sum) begin
      prod <= neg_q ? $signed(~{1'b0, mag} + 50'd1) : $signed({1'b0, mag});
    end
  end

endmodule

// ===== tb/sv/tb_quad_rotor_body_acceleration.sv =====
// Self-checking testbench for the quadrotor body acceleration pipeline.
`timescale 1ns / 1ps

module tb_quad_rotor_body_acceleration;
  import qrba_pkg::*;

  typedef longint unsigned u64_t;

  localparam int NUM_REGS = 8;
  localparam int PIPE_LATENCY = 8;
  localparam int DRAIN_LIMIT = 4000;
  localparam int MAX_REPORTS = 10;
  localparam longint TIMEOUT_NS = 5_000_000;

  localparam longint THRUST_LIMIT = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint ACC_MAX = 64'sd2147483647;
  localparam longint ACC_MIN = -64'sd2147483648;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;
  localparam logic [15:0] DIR_ONE = 16'h4000;
  localparam logic [15:0] DIR_MAX = 16'h7FFF;
  localparam logic [15:0] DIR_MIN = 16'h8000;

  localparam logic [CFG_INDEX_W-1:0] REG_LIST [NUM_REGS] = '{
    REG_THRUST_ACCEL_GAIN, REG_TILT_GAIN, REG_YAW_GAIN, REG_TILT_DAMPING,
    REG_YAW_DAMPING, REG_HORIZONTAL_DRAG, REG_VERTICAL_DRAG, REG_GRAVITY
  };

  typedef enum {CFG_ZERO, CFG_MAX, CFG_MODERATE, CFG_RANDOM} cfg_kind_e;
  typedef enum {READY_ALWAYS, READY_COIN, READY_PERIODIC, READY_LONG_STALL} ready_mode_e;

  class accel_scoreboard;
    result_t     expected_q[$];
    logic [30:0] gains[NUM_REGS];
    int          noted;
    int          checked;
    int          mismatches;

    function new();
      foreach (gains[i]) gains[i] = '0;
      gains[REG_GRAVITY] = GRAVITY_RESET;
      noted = 0;
      checked = 0;
      mismatches = 0;
    endfunction

    function void store_register(logic [CFG_INDEX_W-1:0] idx, logic [31:0] val);
      // drop writes to indexes past the register file
      if (idx < NUM_REGS) gains[idx] = val[30:0];
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function u64_t magnitude(longint a);
      return (a < 0) ? -a : a;
    endfunction

    function longint signed_from(longint a, u64_t r);
      return (a < 0) ? -$signed(r) : $signed(r);
    endfunction

    function longint square_mag(longint v);
      u64_t m;
      m = magnitude(v);
      return (m * m) >> 16;
    endfunction

    function longint drag_square(longint v);
      u64_t m;
      m = magnitude(v);
      return signed_from(v, (m * m) >> 16);
    endfunction

    // Q16.16 times an unsigned gain, truncated toward zero
    function longint scale(longint a, logic [30:0] g);
      u64_t m;
      u64_t gw;
      u64_t r;
      m = magnitude(a);
      gw = g;
      r = (m >> 16) * gw + (((m & 64'hFFFF) * gw) >> 16);
      return signed_from(a, r);
    endfunction

    // thrust times a Q2.14 component, truncated toward zero
    function longint project(longint t, longint c);
      u64_t tu;
      u64_t r;
      tu = t;
      r = (tu * magnitude(c)) >> 14;
      return signed_from(c, r);
    endfunction

    function logic signed [31:0] saturate(longint v);
      if (v > ACC_MAX) return Q_MAX;
      if (v < ACC_MIN) return Q_MIN;
      return v[31:0];
    endfunction

    function result_t predict(item_t it);
      longint vf, vr, vl, vrt, wx, wy, wz, ux, uy, uz, cx, cy, cz;
      longint sf, sr, sl, srt, total;
      result_t r;
      vf = it.speed_front;
      vr = it.speed_rear;
      vl = it.speed_left;
      vrt = it.speed_right;
      wx = it.spin_x;
      wy = it.spin_y;
      wz = it.spin_z;
      ux = it.velocity_x;
      uy = it.velocity_y;
      uz = it.velocity_z;
      cx = $signed(it.thrust_direction[15:0]);
      cy = $signed(it.thrust_direction[31:16]);
      cz = $signed(it.thrust_direction[47:32]);
      sf = square_mag(vf);
      sr = square_mag(vr);
      sl = square_mag(vl);
      srt = square_mag(vrt);
      total = scale(sf + sr + sl + srt, gains[REG_THRUST_ACCEL_GAIN]);
      if (total > THRUST_LIMIT) total = THRUST_LIMIT;
      r.accel_x = saturate(project(total, cx)
                           - scale(drag_square(ux), gains[REG_HORIZONTAL_DRAG]));
      r.accel_y = saturate(project(total, cy)
                           - scale(drag_square(uy), gains[REG_HORIZONTAL_DRAG]));
      r.accel_z = saturate(project(total, cz)
                           - scale(drag_square(uz), gains[REG_VERTICAL_DRAG])
                           - longint'(gains[REG_GRAVITY]));
      r.yaw_accel = saturate(scale(vl + vrt - vf - vr, gains[REG_YAW_GAIN])
                             - scale(wz, gains[REG_YAW_DAMPING]));
      r.pitch_accel = saturate(scale(sl - srt, gains[REG_TILT_GAIN])
                               - scale(wy, gains[REG_TILT_DAMPING]));
      r.roll_accel = saturate(scale(sf - sr, gains[REG_TILT_GAIN])
                              - scale(wx, gains[REG_TILT_DAMPING]));
      return r;
    endfunction

    function void note_item(item_t it);
      expected_q.push_back(predict(it));
      noted++;
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] %s mismatch: expected %0d (0x%08h) got %0d (0x%08h)",
                   $realtime, name, $signed(want), want, $signed(got), got);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] result with nothing pending: 0x%h", $realtime, got);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      compare_field("accel_x", want.accel_x, got.accel_x);
      compare_field("accel_y", want.accel_y, got.accel_y);
      compare_field("accel_z", want.accel_z, got.accel_z);
      compare_field("yaw_accel", want.yaw_accel, got.yaw_accel);
      compare_field("pitch_accel", want.pitch_accel, got.pitch_accel);
      compare_field("roll_accel", want.roll_accel, got.roll_accel);
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   item_valid;
  logic                   item_ready;
  item_t                  item;
  logic                   result_valid;
  logic                   result_ready;
  result_t                result;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [31:0]            cfg_value;

  accel_scoreboard sb = new();
  int settings_count = 0;

  quad_rotor_body_acceleration dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_value    (cfg_value)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Timeout with %0d results still pending", sb.pending());
    $display("Simulation FAILED");
    $finish;
  end

  // Sample handshakes with the values that held just before the edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.store_register(cfg_index, cfg_value);
      if (item_valid && item_ready) sb.note_item(item);
      if (result_valid && result_ready) sb.check_result(result);
    end
  end

  initial begin
    int cyc;
    ready_mode_e mode;
    result_ready = 1'b0;
    cyc = 0;
    mode = READY_ALWAYS;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 64 == 0) mode = ready_mode_e'($urandom_range(0, 3));
      case (mode)
        READY_ALWAYS:   result_ready <= 1'b1;
        READY_COIN:     result_ready <= 1'($urandom_range(0, 1));
        READY_PERIODIC: result_ready <= (cyc % 7) > 2;
        default:        result_ready <= (cyc % 40) >= 25;
      endcase
    end
  end

  function automatic logic signed [31:0] rand_fixed();
    logic signed [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: return Q_MIN;
          1: return Q_MAX;
          2: return '0;
          3: return Q_ONE;
          default: return -1;
        endcase
      end
      1, 2: return r;
      default: return r >>> $urandom_range(7, 24);
    endcase
  endfunction

  function automatic logic [15:0] rand_component();
    case ($urandom_range(0, 5))
      0: return DIR_MIN;
      1: return DIR_MAX;
      2: return DIR_ONE;
      3: return -DIR_ONE;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic item_t rand_item();
    item_t it;
    it.speed_front = rand_fixed();
    it.speed_rear = rand_fixed();
    it.speed_left = rand_fixed();
    it.speed_right = rand_fixed();
    it.spin_x = rand_fixed();
    it.spin_y = rand_fixed();
    it.spin_z = rand_fixed();
    it.velocity_x = rand_fixed();
    it.velocity_y = rand_fixed();
    it.velocity_z = rand_fixed();
    it.thrust_direction = {rand_component(), rand_component(), rand_component()};
    return it;
  endfunction

  function automatic item_t uniform_item(logic signed [31:0] spd, logic signed [31:0] spn,
                                         logic signed [31:0] vel, logic [15:0] d);
    item_t it;
    it.speed_front = spd;
    it.speed_rear = spd;
    it.speed_left = spd;
    it.speed_right = spd;
    it.spin_x = spn;
    it.spin_y = spn;
    it.spin_z = spn;
    it.velocity_x = vel;
    it.velocity_y = vel;
    it.velocity_z = vel;
    it.thrust_direction = {d, d, d};
    return it;
  endfunction

  function automatic logic [31:0] pick_gain(cfg_kind_e kind);
    logic [31:0] v;
    case (kind)
      CFG_ZERO:     v = '0;
      CFG_MAX:      v = 32'h7FFF_FFFF;
      CFG_MODERATE: v = $urandom_range(0, 32'h0003_0000);
      default: begin
        case ($urandom_range(0, 3))
          0: v = '0;
          1: v = 32'h7FFF_FFFF;
          2: v = $urandom_range(0, 32'h0010_0000);
          default: v = $urandom;
        endcase
      end
    endcase
    // bit 31 must be discarded by the block
    v[31] = 1'($urandom_range(0, 1));
    return v;
  endfunction

  function automatic int next_burst_len();
    return ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
  endfunction

  // Hold valid and payload until the transaction is taken; leave valid high.
  task automatic send_item(item_t x);
    item_valid <= 1'b1;
    item <= x;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
  endtask

  task automatic idle(int cycles);
    item_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_value <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic wait_drain();
    int waited;
    waited = 0;
    item_valid <= 1'b0;
    while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  task automatic apply_config(cfg_kind_e kind);
    wait_drain();
    for (int i = 0; i < NUM_REGS; i++) write_reg(REG_LIST[i], pick_gain(kind));
    // an index past the register file must leave every register alone
    write_reg(CFG_INDEX_W'($urandom_range(NUM_REGS, (1 << CFG_INDEX_W) - 1)), $urandom);
    cfg_valid <= 1'b0;
    @(posedge clk);
    settings_count++;
  endtask

  task automatic send_random(int count);
    int burst;
    burst = next_burst_len();
    for (int n = 0; n < count; n++) begin
      send_item(rand_item());
      burst--;
      if (burst == 0) begin
        idle($urandom_range(1, 12));
        burst = next_burst_len();
      end
    end
  endtask

  task automatic run_directed();
    item_t it;
    send_item(uniform_item('0, '0, '0, '0));
    send_item(uniform_item(Q_MAX, Q_MAX, Q_MAX, DIR_MAX));
    send_item(uniform_item(Q_MIN, Q_MIN, Q_MIN, DIR_MIN));
    send_item(uniform_item(-1, -1, -1, 16'hFFFF));
    // level hover: equal rotors, thrust straight up
    it = uniform_item(Q_ONE, '0, '0, '0);
    it.thrust_direction = {DIR_ONE, 16'h0000, 16'h0000};
    send_item(it);
    it = uniform_item('0, '0, '0, '0);
    it.thrust_direction = {DIR_ONE, 16'h0000, 16'h0000};
    it.speed_front = Q_MAX;
    send_item(it);
    it.speed_front = '0;
    it.speed_rear = Q_MIN;
    send_item(it);
    it.speed_rear = '0;
    it.speed_left = Q_MAX;
    send_item(it);
    it.speed_left = '0;
    it.speed_right = Q_MIN;
    send_item(it);
    send_item(uniform_item(-Q_ONE, '0, '0, DIR_ONE));
    send_item(uniform_item('0, Q_MAX, '0, '0));
    send_item(uniform_item('0, Q_MIN, '0, '0));
    send_item(uniform_item('0, '0, Q_MAX, '0));
    send_item(uniform_item('0, '0, Q_MIN, '0));
    send_item(uniform_item('0, '0, -1, '0));
    send_item(uniform_item(32'sh0000_FFFF, 32'sh0000_FFFF, 32'sh0000_FFFF, DIR_ONE));
    // direction of -2.0 and non-unit components are used as given
    it = uniform_item(32'sh0020_0000, Q_ONE, Q_ONE, '0);
    it.thrust_direction = {16'h0000, DIR_MAX, DIR_MIN};
    send_item(it);
    it.thrust_direction = {16'h9ABC, 16'h5678, 16'h1234};
    send_item(it);
    it.speed_left = Q_MIN;
    it.speed_right = Q_MAX;
    it.speed_front = -1;
    send_item(it);
  endtask

  initial begin
    int waited;
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_value = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset register values first
    send_random(10);
    apply_config(CFG_MODERATE);
    run_directed();
    apply_config(CFG_MAX);
    send_random(120);
    apply_config(CFG_MODERATE);
    send_random(130);
    apply_config(CFG_ZERO);
    send_random(60);
    apply_config(CFG_RANDOM);
    send_random(130);
    apply_config(CFG_RANDOM);
    send_random(130);
    apply_config(CFG_MODERATE);
    send_random(70);

    item_valid <= 1'b0;
    waited = 0;
    while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (PIPE_LATENCY * 4) @(posedge clk);

    $display("Covered %0d item transactions and %0d checked results over %0d register settings",
             sb.noted, sb.checked, settings_count + 1);
    $display("Field mismatches: %0d, results never delivered: %0d",
             sb.mismatches, sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/qrba_pkg.sv
hdl/qrba_cfg_regs.sv
hdl/qrba_gain_mul.sv
hdl/qrba_dir_mul.sv
hdl/quad_rotor_body_acceleration.sv
tb/sv/tb_quad_rotor_body_acceleration.sv
